/* rtl/core/gap_over_atr_ratio_defines.svh */
// ----------------------------------------------------------------------------
// Gap over ATR ratio: assertion macros
// Concurrent check wrappers, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef GAP_OVER_ATR_RATIO_DEFINES_SVH
`define GAP_OVER_ATR_RATIO_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GOAR_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("goar: assertion failed");
`define GOAR_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("goar: reset assertion failed");
`else
`define GOAR_ASSERT(name, prop)
`define GOAR_ASSERT_RST(name, prop)
`endif

`endif

/* rtl/core/goar_pkg.sv */
// ----------------------------------------------------------------------------
// Gap over ATR ratio package
// Shared widths, register map and constants.
// ----------------------------------------------------------------------------
package goar_pkg;

  localparam int DATA_W   = 32;
  localparam int PERIOD_W = 6;
  localparam int CNT_W    = PERIOD_W + 1;
  localparam int SUM_W    = DATA_W + PERIOD_W;
  localparam int FRAC_W   = 16;
  localparam int QBITS_W  = 6;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd14;
  localparam logic [DATA_W-1:0]   RATIO_SAT    = 32'hFFFF_FFFF;

  // register index taken from paddr[2]
  localparam logic ADDR_ATR_PERIOD = 1'b0;

endpackage

/* rtl/core/gap_over_atr_ratio.sv */
// ----------------------------------------------------------------------------
// Gap over ATR ratio
// Opening gap against the average true range, unsigned Q16.16, saturating.
// ----------------------------------------------------------------------------
// Bars enter on the bar channel (bar_valid/bar_ready) with open, high, low
// and close in ticks. Each bar after the first yields one gap_ratio
// transaction on the ratio channel (ratio_valid/ratio_ready); the first bar
// after reset only stores its close.
// The APB port holds atr_period at address 0; the window spans
// atr_period+1 true ranges. Write it only while the block is idle.
// A bar is handled in steps: the window of min(atr_period+1, bars
// stored) true ranges is summed through the single ring memory read
// port, then come a multiply, a decision, the serial divider, an output
// load and a return to idle; a zero sum or saturation skips the divider.
// The first bar is taken without leaving idle. bar_ready is high only
// while idle.
// The result sits in an output register; a stalled receiver holds the
// next result in the sequencer until the register frees up.
// Reset (synchronous) returns atr_period to 14, empties the window and
// clears the first-bar flag; the ring memory needs no clearing pass.
// ----------------------------------------------------------------------------
`include "gap_over_atr_ratio_defines.svh"

module gap_over_atr_ratio import goar_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              bar_valid,
  output logic              bar_ready,
  input  logic [DATA_W-1:0] bar_open,
  input  logic [DATA_W-1:0] bar_high,
  input  logic [DATA_W-1:0] bar_low,
  input  logic [DATA_W-1:0] bar_close,
  output logic              ratio_valid,
  input  logic              ratio_ready,
  output logic [DATA_W-1:0] gap_ratio
);

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;
  localparam int PROD_W = DATA_W + CNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]          state;
  logic [PERIOD_W-1:0] atr_period;
  logic [DATA_W-1:0]   last_close;
  logic                seen_first_bar;
  logic [FILL_W-1:0]   fill;
  logic [PTR_W-1:0]    ptr;
  logic [CNT_W-1:0]    left;
  logic                pending;

  logic [DATA_W-1:0]   ring [MAX_WINDOW];
  logic [DATA_W-1:0]   rd_data;
  logic [PTR_W-1:0]    rd_addr;
  logic [DATA_W-1:0]   gap;
  logic [CNT_W-1:0]    count;
  logic [SUM_W-1:0]    range_sum;
  logic [PROD_W-1:0]   prod;
  logic [DATA_W-1:0]   res;

  logic                accept;
  logic                cfg_write;
  logic [DATA_W-1:0]   d_hp, d_lp, d_hl, tr, gap_next;
  logic                hl_ok;
  logic [FILL_W-1:0]   fill_next;
  logic [PTR_W-1:0]    ptr_next, rd_addr_next;
  logic [CNT_W-1:0]    period_cnt, count_next;
  logic                sum_zero, ovf;
  logic [SUM_W-1:0]    num_hi;
  logic                div_start, div_busy, div_done;
  logic [DATA_W-1:0]   div_quot;
  logic                out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == ADDR_ATR_PERIOD) ? {26'd0, atr_period} : 32'd0;

  assign bar_ready = (state == ST_IDLE);
  assign accept    = bar_valid && bar_ready;
  assign out_free  = !ratio_valid || ratio_ready;

  always_comb begin
    d_hp  = (bar_high >= last_close) ? bar_high - last_close : last_close - bar_high;
    d_lp  = (bar_low >= last_close) ? bar_low - last_close : last_close - bar_low;
    hl_ok = bar_high >= bar_low;
    d_hl  = bar_high - bar_low;
    tr    = (d_lp > d_hp) ? d_lp : d_hp;
    if (hl_ok && d_hl > tr) begin
      tr = d_hl;
    end
    gap_next = (bar_open >= last_close) ? bar_open - last_close : last_close - bar_open;
    fill_next = (fill == FILL_W'(MAX_WINDOW)) ? fill : fill + 1'b1;
    ptr_next = (ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr + 1'b1;
    rd_addr_next = (rd_addr == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_addr - 1'b1;
    period_cnt = {1'b0, atr_period} + 1'b1;
    count_next = (CMP_W'(fill_next) < CMP_W'(period_cnt)) ? CNT_W'(fill_next) : period_cnt;
    num_hi   = SUM_W'(prod[PROD_W-1:FRAC_W]);
    sum_zero = (range_sum == '0);
    ovf      = num_hi >= range_sum;
  end

  assign div_start = (state == ST_DIV) && !sum_zero && !ovf;

  goar_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (num_hi),
    .num_lo ({prod[FRAC_W-1:0], {FRAC_W{1'b0}}}),
    .den    (range_sum),
    .busy   (div_busy),
    .done   (div_done),
    .quot   (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      atr_period     <= PERIOD_RESET;
      last_close     <= '0;
      seen_first_bar <= 1'b0;
      fill           <= '0;
      ptr            <= '0;
      left           <= '0;
      pending        <= 1'b0;
      ratio_valid    <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == ADDR_ATR_PERIOD) begin
        atr_period <= pwdata[PERIOD_W-1:0];
      end
      if (state == ST_DONE && out_free) begin
        ratio_valid <= 1'b1;
      end else if (ratio_ready) begin
        ratio_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_close <= bar_close;
            if (!seen_first_bar) begin
              seen_first_bar <= 1'b1;
            end else begin
              ptr     <= ptr_next;
              fill    <= fill_next;
              left    <= count_next;
              pending <= 1'b0;
              state   <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          pending <= (left != '0);
          if (left != '0) begin
            left <= left - 1'b1;
          end else if (!pending) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          state <= div_start ? ST_RUN : ST_DONE;
        end
        ST_RUN: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && seen_first_bar) begin
      ring[ptr] <= tr;
    end
    if (state == ST_SUM && left != '0) begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          gap       <= gap_next;
          count     <= count_next;
          range_sum <= '0;
          rd_addr   <= ptr;
        end
      end
      ST_SUM: begin
        if (pending) begin
          range_sum <= range_sum + SUM_W'(rd_data);
        end
        if (left != '0) begin
          rd_addr <= rd_addr_next;
        end
      end
      ST_MUL: begin
        prod <= PROD_W'(gap) * PROD_W'(count);
      end
      ST_DIV: begin
        if (sum_zero) begin
          res <= (gap[DATA_W-1:FRAC_W] != '0) ? RATIO_SAT
                                              : {gap[FRAC_W-1:0], {FRAC_W{1'b0}}};
        end else if (ovf) begin
          res <= RATIO_SAT;
        end
      end
      ST_RUN: begin
        if (div_done) begin
          res <= div_quot;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          gap_ratio <= res;
        end
      end
      default: begin
      end
    endcase
  end

  `GOAR_ASSERT(a_ready_div_idle, bar_ready |-> !div_busy)
  `GOAR_ASSERT(a_div_done_run, div_done |-> (state == ST_RUN))
  `GOAR_ASSERT(a_fill_bound, fill <= FILL_W'(MAX_WINDOW))
  `GOAR_ASSERT(a_sum_reads, (state == ST_SUM) |-> (left <= count))
  `GOAR_ASSERT_RST(a_reset_idle, rst |=> (state == ST_IDLE) && !ratio_valid)

endmodule

/* rtl/core/goar_div.sv */
// ----------------------------------------------------------------------------
// Gap over ATR ratio: serial divider
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// ----------------------------------------------------------------------------
module goar_div import goar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  num_hi,
  input  logic [DATA_W-1:0] num_lo,
  input  logic [SUM_W-1:0]  den,
  output logic              busy,
  output logic              done,
  output logic [DATA_W-1:0] quot
);

  logic [SUM_W-1:0]   rem;
  logic [DATA_W-1:0]  lo;
  logic [QBITS_W-1:0] cnt;
  logic [SUM_W:0]     shifted;
  logic               ge;
  logic [SUM_W:0]     diff;

  always_comb begin
    shifted = {rem, lo[DATA_W-1]};
    ge      = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= QBITS_W'(DATA_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == QBITS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num_hi;
      lo   <= num_lo;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      lo   <= {lo[DATA_W-2:0], 1'b0};
      quot <= {quot[DATA_W-2:0], ge};
    end
  end

endmodule
